### sv/lms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_pkg
// Shared widths, sequencer state and control bundles for the LMS FIR.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int SAMPLE_W = 16;  // Q1.15 samples and output
  localparam int TAP_W    = 24;  // Q4.20 taps
  localparam int STEP_W   = 16;  // Q0.16 step size
  localparam int DIFF_W   = 17;  // window[0] - y
  localparam int ERR_W    = 34;  // step * diff, Q3.31
  localparam int MPROD_W  = 40;  // tap * sample, Q5.35
  localparam int PROD_W   = 50;  // err * sample, Q4.46
  localparam int UPD_SH   = 26;  // Q4.46 -> Q4.20
  localparam int Y_SH     = 20;  // Q5.35 -> Q1.15

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_ACC   = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_ERR   = 7'b0010000,
    S_UMUL  = 7'b0100000,
    S_UPD   = 7'b1000000
  } lms_state_t;

  // Per-cell control, broadcast along the chain
  typedef struct packed {
    logic shift;  // take neighbor's sample
    logic mul;    // product <= tap * sample
    logic pass;   // product <= neighbor's product
    logic umul;   // product <= err * sample
    logic upd;    // tap <= sat(tap + round(product))
  } cell_ctrl_t;

  // Accumulator / error unit control
  typedef struct packed {
    logic clear;
    logic add;
    logic fin;    // register rounded, saturated y
    logic err;    // register step * (window[0] - y)
  } tail_ctrl_t;

endpackage

### sv/lms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_cell
// One tap of the chain: holds a sample, a weight and a product register.
// ----------------------------------------------------------------------------
module lms_cell #(
  parameter logic signed [lms_pkg::TAP_W-1:0] TAP_INIT = 24'sd65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lms_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [lms_pkg::SAMPLE_W-1:0] win_in,
  input  logic signed [lms_pkg::PROD_W-1:0]   prod_in,
  input  logic signed [lms_pkg::ERR_W-1:0]    err,
  output logic signed [lms_pkg::SAMPLE_W-1:0] win_out,
  output logic signed [lms_pkg::PROD_W-1:0]   prod_out
);
  import lms_pkg::*;

  localparam logic signed [TAP_W+1:0] TSUM_MAX = (TAP_W+2)'(8388607);
  localparam logic signed [TAP_W+1:0] TSUM_MIN = (TAP_W+2)'(-8388608);

  logic signed [SAMPLE_W-1:0] win_r, win_nxt;
  logic signed [TAP_W-1:0]    tap_r, tap_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [MPROD_W-1:0]  mprod;
  logic signed [PROD_W-1:0]   uprod;
  logic signed [PROD_W:0]     rsum;
  logic signed [TAP_W:0]      delta;
  logic signed [TAP_W+1:0]    tsum;

  assign mprod = tap_r * win_r;
  assign uprod = err * win_r;

  // Round half up to Q4.20, add and clamp
  assign rsum  = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(64'sd1 <<< (UPD_SH - 1));
  assign delta = rsum[PROD_W:UPD_SH];
  assign tsum  = {{2{tap_r[TAP_W-1]}}, tap_r} + {delta[TAP_W], delta};

  always_comb begin
    win_nxt  = ctrl.shift ? win_in : win_r;
    prod_nxt = prod_r;
    if (ctrl.mul) begin
      prod_nxt = {{(PROD_W-MPROD_W){mprod[MPROD_W-1]}}, mprod};
    end else if (ctrl.pass) begin
      prod_nxt = prod_in;
    end else if (ctrl.umul) begin
      prod_nxt = uprod;
    end
    tap_nxt = tap_r;
    if (ctrl.upd) begin
      if (tsum > TSUM_MAX) begin
        tap_nxt = TSUM_MAX[TAP_W-1:0];
      end else if (tsum < TSUM_MIN) begin
        tap_nxt = TSUM_MIN[TAP_W-1:0];
      end else begin
        tap_nxt = tsum[TAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      tap_r <= TAP_INIT;
    end else begin
      win_r <= win_nxt;
      tap_r <= tap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign win_out  = win_r;
  assign prod_out = prod_r;

endmodule

### sv/lms_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_tail
// Chain end: accumulate products, round and clamp y, form the error.
// ----------------------------------------------------------------------------
module lms_tail #(
  parameter int ACC_W = 44
) (
  input  logic                                clk,
  input  lms_pkg::tail_ctrl_t                 ctrl,
  input  logic signed [lms_pkg::PROD_W-1:0]   prod_in,
  input  logic signed [lms_pkg::SAMPLE_W-1:0] oldest,
  input  logic        [lms_pkg::STEP_W-1:0]   step,
  output logic signed [lms_pkg::SAMPLE_W-1:0] y_sat,
  output logic signed [lms_pkg::ERR_W-1:0]    err
);
  import lms_pkg::*;

  localparam int SH_W = ACC_W + 1 - Y_SH;
  localparam logic signed [SH_W-1:0] Y_MAX = SH_W'(32767);
  localparam logic signed [SH_W-1:0] Y_MIN = SH_W'(-32768);

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W:0]    rnd;
  logic signed [SH_W-1:0]   sh;
  logic signed [SAMPLE_W-1:0] y_r;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  err_prod;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.add) begin
      acc_nxt = acc_r + {{(ACC_W-MPROD_W){prod_in[MPROD_W-1]}}, prod_in[MPROD_W-1:0]};
    end
  end

  assign rnd = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(64'sd1 <<< (Y_SH - 1));
  assign sh  = rnd[ACC_W:Y_SH];

  always_comb begin
    if (sh > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_W-1:0];
    end else if (sh < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_W-1:0];
    end else begin
      y_sat = sh[SAMPLE_W-1:0];
    end
  end

  assign diff     = {oldest[SAMPLE_W-1], oldest} - {y_r[SAMPLE_W-1], y_r};
  assign err_prod = $signed({1'b0, step}) * diff;

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctrl.fin) begin
      y_r <= y_sat;
    end
    if (ctrl.err) begin
      err_r <= err_prod;
    end
  end

  assign err = err_r;

endmodule

### sv/lms_adaptive_fir.sv
`timescale 1ns / 1ps
// An input transfer shifts the window; the product, accumulate and rounding steps
//   follow, and rounding registers y into the output register. The product shift-out
//   feeds one chain product a cycle into the single accumulator; rounding also waits
//   on a full output register, and a new sample is taken only after the tap update.
// Reset (rst_n low, synchronous): window cleared, taps set to round(2^20/TAPS),
//   step size 655, output register empty.
// ----------------------------------------------------------------------------
// lms_adaptive_fir
// LMS adaptive FIR filter built as a chain of tap cells with a sequencer.
// ----------------------------------------------------------------------------
module lms_adaptive_fir #(
  parameter int TAPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: step_size, unsigned Q0.16
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] filtered
);
  import lms_pkg::*;

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W = MPROD_W + $clog2(TAPS) + 1;
  localparam logic signed [TAP_W-1:0] TAP_INIT =
    TAP_W'(((1 << 20) + TAPS / 2) / TAPS);

  // Sequencer
  lms_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0] step_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r;

  logic in_xfer;
  logic out_xfer;
  logic fire_round;

  cell_ctrl_t cctrl;
  tail_ctrl_t tctrl;

  logic signed [SAMPLE_W-1:0] win_chain  [TAPS];
  logic signed [PROD_W-1:0]   prod_chain [TAPS];
  logic signed [ERR_W-1:0]    err;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign out_xfer   = out_valid_r & out_tready;
  // The output register must be free (or draining) before y lands in it
  assign fire_round = (state_r == S_ROUND) & (~out_valid_r | out_tready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cctrl     = '0;
    tctrl     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cctrl.shift = 1'b1;   // advance the window by one sample
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cctrl.mul   = 1'b1;
        tctrl.clear = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        // Shift products toward cell 0; add the one leaving the chain
        cctrl.pass = 1'b1;
        tctrl.add  = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TAPS - 1)) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (fire_round) begin
          tctrl.fin = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        tctrl.err = 1'b1;
        state_nxt = S_UMUL;
      end
      S_UMUL: begin
        cctrl.umul = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cctrl.upd = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_round) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
    end
  end

  // Hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (fire_round) begin
      out_data_r <= y_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Tap chain: cell 0 holds the oldest sample, cell TAPS-1 the newest
  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    logic signed [SAMPLE_W-1:0] win_in;
    logic signed [PROD_W-1:0]   prod_in;
    if (j == TAPS - 1) begin : g_last
      assign win_in  = $signed(in_tdata);
      assign prod_in = '0;
    end else begin : g_mid
      assign win_in  = win_chain[j+1];
      assign prod_in = prod_chain[j+1];
    end
    lms_cell #(
      .TAP_INIT (TAP_INIT)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cctrl),
      .win_in   (win_in),
      .prod_in  (prod_in),
      .err      (err),
      .win_out  (win_chain[j]),
      .prod_out (prod_chain[j])
    );
  end

  lms_tail #(
    .ACC_W (ACC_W)
  ) u_tail (
    .clk     (clk),
    .ctrl    (tctrl),
    .prod_in (prod_chain[0]),
    .oldest  (win_chain[0]),
    .step    (step_r),
    .y_sat   (y_sat),
    .err     (err)
  );

  // A result appears only out of the rounding step
  a_out_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ROUND))
    else $error("output valid rose outside rounding step");

  // Every product has been summed before rounding
  a_acc_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && $past(state_r == S_ACC)) |-> $past(cnt_r) == CNT_W'(TAPS - 1))
    else $error("rounding entered before all products were summed");

  // A blocked output stalls the sequencer in the rounding step
  a_round_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && out_valid_r && !out_tready) |=> state_r == S_ROUND)
    else $error("sequencer left rounding step while output was blocked");

  // An input transfer always starts the product step
  a_xfer_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_MUL)
    else $error("input transfer did not start a filter pass");

endmodule
